// File: hdl/fee_pkg.sv
// shared types, constants and control structs for the flash eeprom emulation block
`default_nettype none

package fee_pkg;

    // geometry and field widths
    localparam int DEF_PAGE_SLOTS = 256;
    localparam int MAX_KEYS       = 4;
    localparam int NUM_KEYS       = 4;
    localparam int KEY_W          = 16;
    localparam int VAL_W          = 16;
    localparam int CNT_W          = 3;
    localparam int IDX_W          = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int FIRST_KEY_OFS  = 3;

    // page header and erased flash codes
    localparam logic [VAL_W-1:0] HDR_ERASED  = 16'hFFFF;
    localparam logic [VAL_W-1:0] HDR_RECEIVE = 16'hEEEE;
    localparam logic [VAL_W-1:0] HDR_VALID   = 16'h0000;
    localparam logic [VAL_W-1:0] HW_ERASED   = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_RECOVER,
        OP_NOP
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOT_FOUND,
        ST_NO_VALID,
        ST_FULL
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_COUNT,
        CFG_KEY_0,
        CFG_KEY_1,
        CFG_KEY_2,
        CFG_KEY_3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        HC_ERASED,
        HC_RECEIVE,
        HC_VALID,
        HC_OTHER
    } t_hdr_class;

    // flash address sources
    typedef enum logic [2:0] {
        AS_KEY,
        AS_DATA,
        AS_OFF,
        AS_HDR,
        AS_FIRST
    } t_addr_sel;

    // flash write data sources
    typedef enum logic [2:0] {
        WD_ERASED,
        WD_KEY,
        WD_VAL,
        WD_RECEIVE,
        WD_VALID
    } t_wd_sel;

    typedef enum logic [1:0] {
        PG_READ,
        PG_WRITE,
        PG_CMD
    } t_page_src;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ERASE,
        ACT_HDR_VALID
    } t_act_kind;

    typedef struct packed {
        t_act_kind kind;
        logic      page;
    } t_act;

    // controller to datapath
    typedef struct packed {
        logic      cap_in;
        t_addr_sel addr_sel;
        logic      mem_we;
        t_wd_sel   wd_sel;
        logic      page_ld;
        t_page_src page_src;
        logic      page;
        logic      slot_top;
        logic      slot_zero;
        logic      slot_dec;
        logic      slot_inc;
        logic      off_inc;
        logic      off_clr;
        logic      flag_ld;
        logic      val_ld;
        logic      skip_in;
        logic      skip_mem;
        logic      use_in;
        logic      use_list;
        logic      idx_clr;
        logic      idx_inc;
        logic      res_ld;
        t_status   res_st;
        logic      res_val;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       key_match;
        logic       hw_erased;
        logic       flag;
        logic       slot_end;
        logic       slot_one;
        logic       off_last;
        logic       rp_none;
        logic       rp;
        logic       wp_none;
        t_hdr_class h0;
        t_hdr_class h1;
        logic       idx_done;
        logic       idx_skip;
    } t_sts;

    typedef enum logic [4:0] {
        S_CLR0,
        S_CLR1,
        S_IDLE,
        S_DISP,
        S_RS_START,
        S_RS_ISSUE,
        S_RS_CHK,
        S_RS_DATA,
        S_RS_GOT,
        S_AP_START,
        S_AP_RD0,
        S_AP_RD1,
        S_AP_CHK,
        S_AP_WR0,
        S_AP_WR1,
        S_ER,
        S_HDR,
        S_RF_ISSUE,
        S_RF_GOT
    } t_state;

    typedef enum logic [3:0] {
        P_RD,
        P_WAPP1,
        P_WHRX,
        P_WAPP2,
        P_RFIRST,
        CP_TEST,
        CP_READ,
        CP_APP,
        P_PLAN,
        P_NONE
    } t_step;

endpackage

`default_nettype wire

// File: hdl/fee_ram.sv
// generic single write port ram with registered read
`default_nettype none

module fee_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/fee_ctrl.sv
// controller state machine sequencing reads, appends, erases and page transfers
`default_nettype none

module fee_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire fee_pkg::t_opcode i_opcode,
    input  wire fee_pkg::t_sts    i_sts,
    output fee_pkg::t_cmd         o_cmd,
    output logic                  o_busy
);
    import fee_pkg::*;

    typedef struct packed {
        logic       copy;
        logic       dst;
        t_act [2:0] plan;
    } t_rec;

    t_state     r_state, n_state;
    t_step      r_step, n_step;
    t_status    r_st, n_st;
    t_act [2:0] r_plan, n_plan;
    logic       r_hv, n_hv;
    t_rec       w_rec;
    t_cmd       w_cmd;

    function automatic t_act mk(input t_act_kind k, input logic p);
        t_act a;
        a.kind = k;
        a.page = p;
        return a;
    endfunction

    // header repair decision from the two header classes
    function automatic t_rec rec_decode(input t_hdr_class h0, input t_hdr_class h1);
        t_rec r;
        t_act [2:0] fmt;
        fmt = {mk(ACT_ERASE, 1'b1), mk(ACT_HDR_VALID, 1'b0), mk(ACT_ERASE, 1'b0)};
        r.copy = 1'b0;
        r.dst  = 1'b0;
        r.plan = fmt;
        unique case (h0)
            HC_ERASED: begin
                if (h1 == HC_VALID) begin
                    r.plan = {mk(ACT_NONE, 1'b0), mk(ACT_NONE, 1'b0), mk(ACT_ERASE, 1'b0)};
                end else if (h1 == HC_RECEIVE) begin
                    r.plan = {mk(ACT_NONE, 1'b0), mk(ACT_HDR_VALID, 1'b1),
                              mk(ACT_ERASE, 1'b0)};
                end
            end
            HC_RECEIVE: begin
                if (h1 == HC_VALID) begin
                    r.copy = 1'b1;
                    r.dst  = 1'b0;
                    r.plan = {mk(ACT_NONE, 1'b0), mk(ACT_ERASE, 1'b1),
                              mk(ACT_HDR_VALID, 1'b0)};
                end else if (h1 == HC_ERASED) begin
                    r.plan = {mk(ACT_NONE, 1'b0), mk(ACT_HDR_VALID, 1'b0),
                              mk(ACT_ERASE, 1'b1)};
                end
            end
            HC_VALID: begin
                if (h1 == HC_ERASED) begin
                    r.plan = {mk(ACT_NONE, 1'b0), mk(ACT_NONE, 1'b0), mk(ACT_ERASE, 1'b1)};
                end else if (h1 != HC_VALID) begin
                    r.copy = 1'b1;
                    r.dst  = 1'b1;
                    r.plan = {mk(ACT_NONE, 1'b0), mk(ACT_ERASE, 1'b0),
                              mk(ACT_HDR_VALID, 1'b1)};
                end
            end
            HC_OTHER: begin
                r.plan = fmt;
            end
        endcase
        return r;
    endfunction

    assign w_rec = rec_decode(i_sts.h0, i_sts.h1);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR0;
            r_step  <= P_NONE;
            r_st    <= ST_OK;
            r_plan  <= '0;
            r_hv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_st    <= n_st;
            r_plan  <= n_plan;
            r_hv    <= n_hv;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_st    = r_st;
        n_plan  = r_plan;
        n_hv    = r_hv;
        unique case (r_state)
            S_CLR0: begin
                if (i_sts.off_last) n_state = S_CLR1;
            end
            S_CLR1: begin
                if (i_sts.off_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_opcode)
                        OP_READ: begin
                            n_step  = P_RD;
                            n_state = S_RS_START;
                        end
                        OP_WRITE: begin
                            n_step  = P_WAPP1;
                            n_state = S_AP_START;
                        end
                        OP_RECOVER: begin
                            n_plan = w_rec.plan;
                            if (w_rec.copy) begin
                                n_step  = P_RFIRST;
                                n_state = S_RF_ISSUE;
                            end else begin
                                n_step  = P_PLAN;
                                n_state = S_DISP;
                            end
                        end
                        OP_NOP: begin
                            n_step  = P_NONE;
                            n_state = S_DISP;
                        end
                    endcase
                end
            end
            S_DISP: begin
                unique case (r_step)
                    P_RD: n_state = S_IDLE;
                    P_WAPP1: begin
                        if (r_st != ST_FULL || i_sts.rp_none) begin
                            n_state = S_IDLE;
                        end else begin
                            n_plan  = {mk(ACT_NONE, 1'b0), mk(ACT_HDR_VALID, ~i_sts.rp),
                                       mk(ACT_ERASE, i_sts.rp)};
                            n_hv    = 1'b0;
                            n_step  = P_WHRX;
                            n_state = S_HDR;
                        end
                    end
                    P_WHRX: begin
                        n_step  = P_WAPP2;
                        n_state = S_AP_START;
                    end
                    P_WAPP2: begin
                        if (r_st != ST_OK) n_state = S_IDLE;
                        else n_step = CP_TEST;
                    end
                    P_RFIRST: n_step = CP_TEST;
                    CP_TEST: begin
                        if (i_sts.idx_done) begin
                            n_step = P_PLAN;
                        end else if (!i_sts.idx_skip) begin
                            n_step  = CP_READ;
                            n_state = S_RS_START;
                        end
                    end
                    CP_READ: begin
                        if (r_st == ST_OK) begin
                            n_step  = CP_APP;
                            n_state = S_AP_START;
                        end else begin
                            n_step = CP_TEST;
                        end
                    end
                    CP_APP: begin
                        if (r_st != ST_OK) n_state = S_IDLE;
                        else n_step = CP_TEST;
                    end
                    P_PLAN: begin
                        n_plan = {mk(ACT_NONE, 1'b0), r_plan[2], r_plan[1]};
                        unique case (r_plan[0].kind)
                            ACT_ERASE:     n_state = S_ER;
                            ACT_HDR_VALID: begin
                                n_hv    = 1'b1;
                                n_state = S_HDR;
                            end
                            default:       n_state = S_IDLE;
                        endcase
                    end
                    P_NONE: n_state = S_IDLE;
                    default: n_state = S_IDLE;
                endcase
            end
            S_RS_START: begin
                if (i_sts.rp_none) begin
                    n_st    = ST_NO_VALID;
                    n_state = S_DISP;
                end else begin
                    n_state = S_RS_ISSUE;
                end
            end
            S_RS_ISSUE: n_state = S_RS_CHK;
            S_RS_CHK: begin
                if (i_sts.key_match) begin
                    n_state = S_RS_DATA;
                end else if (i_sts.slot_one) begin
                    n_st    = ST_NOT_FOUND;
                    n_state = S_DISP;
                end else begin
                    n_state = S_RS_ISSUE;
                end
            end
            S_RS_DATA: n_state = S_RS_GOT;
            S_RS_GOT: begin
                n_st    = ST_OK;
                n_state = S_DISP;
            end
            S_AP_START: begin
                if (i_sts.wp_none) begin
                    n_st    = ST_NO_VALID;
                    n_state = S_DISP;
                end else begin
                    n_state = S_AP_RD0;
                end
            end
            S_AP_RD0: n_state = S_AP_RD1;
            S_AP_RD1: n_state = S_AP_CHK;
            S_AP_CHK: begin
                if (i_sts.hw_erased && i_sts.flag) begin
                    n_state = S_AP_WR0;
                end else if (i_sts.slot_end) begin
                    n_st    = ST_FULL;
                    n_state = S_DISP;
                end else begin
                    n_state = S_AP_RD0;
                end
            end
            S_AP_WR0: n_state = S_AP_WR1;
            S_AP_WR1: begin
                n_st    = ST_OK;
                n_state = S_DISP;
            end
            S_ER: begin
                if (i_sts.off_last) n_state = S_DISP;
            end
            S_HDR: n_state = S_DISP;
            S_RF_ISSUE: n_state = S_RF_GOT;
            S_RF_GOT: n_state = S_DISP;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        w_cmd          = '0;
        w_cmd.addr_sel = AS_OFF;
        w_cmd.wd_sel   = WD_ERASED;
        w_cmd.page_src = PG_CMD;
        w_cmd.res_st   = ST_OK;
        unique case (r_state)
            S_CLR0, S_CLR1: begin
                w_cmd.mem_we   = 1'b1;
                w_cmd.addr_sel = AS_OFF;
                w_cmd.wd_sel   = WD_ERASED;
                w_cmd.off_inc  = 1'b1;
                if (i_sts.off_last) begin
                    w_cmd.off_clr = 1'b1;
                    w_cmd.page_ld = 1'b1;
                    w_cmd.page    = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.cap_in = 1'b1;
                    w_cmd.use_in = 1'b1;
                    if (i_opcode == OP_RECOVER && w_rec.copy) begin
                        w_cmd.page_ld = 1'b1;
                        w_cmd.page    = w_rec.dst;
                    end
                end
            end
            S_DISP: begin
                unique case (r_step)
                    P_RD: begin
                        w_cmd.res_ld  = 1'b1;
                        w_cmd.res_st  = r_st;
                        w_cmd.res_val = (r_st == ST_OK);
                    end
                    P_WAPP1: begin
                        if (r_st != ST_FULL) begin
                            w_cmd.res_ld = 1'b1;
                            w_cmd.res_st = r_st;
                        end else if (i_sts.rp_none) begin
                            w_cmd.res_ld = 1'b1;
                            w_cmd.res_st = ST_NO_VALID;
                        end else begin
                            w_cmd.page_ld = 1'b1;
                            w_cmd.page    = ~i_sts.rp;
                        end
                    end
                    P_WHRX: begin
                        w_cmd.use_in = 1'b1;
                    end
                    P_WAPP2: begin
                        if (r_st != ST_OK) begin
                            w_cmd.res_ld = 1'b1;
                            w_cmd.res_st = r_st;
                        end else begin
                            w_cmd.skip_in = 1'b1;
                            w_cmd.idx_clr = 1'b1;
                        end
                    end
                    P_RFIRST: w_cmd.idx_clr = 1'b1;
                    CP_TEST: begin
                        if (!i_sts.idx_done) begin
                            if (i_sts.idx_skip) w_cmd.idx_inc = 1'b1;
                            else w_cmd.use_list = 1'b1;
                        end
                    end
                    CP_READ: begin
                        if (r_st != ST_OK) w_cmd.idx_inc = 1'b1;
                    end
                    CP_APP: begin
                        if (r_st != ST_OK) begin
                            w_cmd.res_ld = 1'b1;
                            w_cmd.res_st = r_st;
                        end else begin
                            w_cmd.idx_inc = 1'b1;
                        end
                    end
                    P_PLAN: begin
                        if (r_plan[0].kind == ACT_NONE) begin
                            w_cmd.res_ld = 1'b1;
                            w_cmd.res_st = ST_OK;
                        end else begin
                            w_cmd.page_ld = 1'b1;
                            w_cmd.page    = r_plan[0].page;
                        end
                    end
                    P_NONE: begin
                        w_cmd.res_ld = 1'b1;
                        w_cmd.res_st = ST_OK;
                    end
                    default: begin
                        w_cmd.res_ld = 1'b1;
                        w_cmd.res_st = ST_OK;
                    end
                endcase
            end
            S_RS_START: begin
                if (!i_sts.rp_none) begin
                    w_cmd.page_ld  = 1'b1;
                    w_cmd.page_src = PG_READ;
                    w_cmd.slot_top = 1'b1;
                end
            end
            S_RS_ISSUE: w_cmd.addr_sel = AS_KEY;
            S_RS_CHK: begin
                if (!i_sts.key_match && !i_sts.slot_one) w_cmd.slot_dec = 1'b1;
            end
            S_RS_DATA: w_cmd.addr_sel = AS_DATA;
            S_RS_GOT: w_cmd.val_ld = 1'b1;
            S_AP_START: begin
                if (!i_sts.wp_none) begin
                    w_cmd.page_ld   = 1'b1;
                    w_cmd.page_src  = PG_WRITE;
                    w_cmd.slot_zero = 1'b1;
                end
            end
            S_AP_RD0: w_cmd.addr_sel = AS_DATA;
            S_AP_RD1: begin
                w_cmd.addr_sel = AS_KEY;
                w_cmd.flag_ld  = 1'b1;
            end
            S_AP_CHK: begin
                if (!(i_sts.hw_erased && i_sts.flag) && !i_sts.slot_end) begin
                    w_cmd.slot_inc = 1'b1;
                end
            end
            S_AP_WR0: begin
                w_cmd.mem_we   = 1'b1;
                w_cmd.addr_sel = AS_DATA;
                w_cmd.wd_sel   = WD_VAL;
            end
            S_AP_WR1: begin
                w_cmd.mem_we   = 1'b1;
                w_cmd.addr_sel = AS_KEY;
                w_cmd.wd_sel   = WD_KEY;
            end
            S_ER: begin
                w_cmd.mem_we   = 1'b1;
                w_cmd.addr_sel = AS_OFF;
                w_cmd.wd_sel   = WD_ERASED;
                w_cmd.off_inc  = 1'b1;
                w_cmd.off_clr  = i_sts.off_last;
            end
            S_HDR: begin
                w_cmd.mem_we   = 1'b1;
                w_cmd.addr_sel = AS_HDR;
                w_cmd.wd_sel   = r_hv ? WD_VALID : WD_RECEIVE;
            end
            S_RF_ISSUE: w_cmd.addr_sel = AS_FIRST;
            S_RF_GOT: w_cmd.skip_mem = 1'b1;
            default: ;
        endcase
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    // no flash write while waiting for a command
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_cmd.mem_we)
        else $error("flash written while idle");

    // a data halfword is always followed by its key halfword
    a_pair_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AP_WR0) |=> (r_state == S_AP_WR1))
        else $error("slot pair write split");

    // results only come out of the dispatch step
    a_res_from_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_ld |-> (r_state == S_DISP))
        else $error("result issued outside dispatch");
`endif

endmodule

`default_nettype wire

// File: hdl/fee_dpath.sv
// datapath: flash array, header mirrors, slot counters, key list and result registers
`default_nettype none

module fee_dpath #(
    parameter int PAGE_SLOTS = fee_pkg::DEF_PAGE_SLOTS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fee_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fee_pkg::VAL_W-1:0]      i_cfg_data,
    input  wire logic [fee_pkg::KEY_W-1:0]      i_var_key,
    input  wire logic [fee_pkg::VAL_W-1:0]      i_write_value,
    input  wire fee_pkg::t_cmd                  i_cmd,
    output fee_pkg::t_sts                       o_sts,
    output logic      [1:0]                     o_status,
    output logic      [fee_pkg::VAL_W-1:0]      o_read_value,
    output logic                                o_result_valid
);
    import fee_pkg::*;

    localparam int PAGE_HW = 2 * PAGE_SLOTS;
    localparam int DEPTH   = 4 * PAGE_SLOTS;
    localparam int AW      = $clog2(DEPTH);
    localparam int SW      = $clog2(PAGE_SLOTS);
    localparam int OW      = $clog2(PAGE_HW);

    logic [KEY_W-1:0] r_key [NUM_KEYS];
    logic [CNT_W-1:0] r_key_count;
    logic [VAL_W-1:0] r_hdr0, r_hdr1;
    logic [KEY_W-1:0] r_in_key, r_skip;
    logic [VAL_W-1:0] r_in_val, r_val, r_rv;
    logic             r_use_list, r_page, r_flag, r_out_valid;
    logic [SW-1:0]    r_slot;
    logic [OW-1:0]    r_off;
    logic [IDX_W-1:0] r_idx;
    t_status          r_status;

    logic [AW-1:0]    w_base, w_addr;
    logic [VAL_W-1:0] w_wdata, w_rdata;
    logic [KEY_W-1:0] w_list_key, w_op_key;
    logic [VAL_W-1:0] w_op_val;
    logic [CNT_W-1:0] w_n;
    logic             w_rp_none, w_rp, w_wp_none, w_wp;

    function automatic t_hdr_class classify(input logic [VAL_W-1:0] h);
        t_hdr_class c;
        if (h == HDR_ERASED) c = HC_ERASED;
        else if (h == HDR_RECEIVE) c = HC_RECEIVE;
        else if (h == HDR_VALID) c = HC_VALID;
        else c = HC_OTHER;
        return c;
    endfunction

    // operand selection
    assign w_list_key = r_key[r_idx[1:0]];
    assign w_op_key   = r_use_list ? w_list_key : r_in_key;
    assign w_op_val   = r_use_list ? r_val : r_in_val;
    assign w_n        = (r_key_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : r_key_count;

    // flash address
    assign w_base = r_page ? AW'(PAGE_HW) : '0;
    always_comb begin
        unique case (i_cmd.addr_sel)
            AS_KEY:   w_addr = w_base + AW'({r_slot, 1'b1});
            AS_DATA:  w_addr = w_base + AW'({r_slot, 1'b0});
            AS_OFF:   w_addr = w_base + AW'(r_off);
            AS_HDR:   w_addr = w_base;
            AS_FIRST: w_addr = w_base + AW'(FIRST_KEY_OFS);
            default:  w_addr = w_base;
        endcase
    end

    // flash write data
    always_comb begin
        unique case (i_cmd.wd_sel)
            WD_ERASED:  w_wdata = HW_ERASED;
            WD_KEY:     w_wdata = w_op_key;
            WD_VAL:     w_wdata = w_op_val;
            WD_RECEIVE: w_wdata = HDR_RECEIVE;
            WD_VALID:   w_wdata = HDR_VALID;
            default:    w_wdata = HW_ERASED;
        endcase
    end

    fee_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_flash (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // page selection from header mirrors
    always_comb begin
        w_rp_none = !(r_hdr0 == HDR_VALID || r_hdr1 == HDR_VALID);
        w_rp      = (r_hdr0 != HDR_VALID);
        w_wp_none = 1'b0;
        w_wp      = 1'b0;
        if (r_hdr1 == HDR_VALID) begin
            w_wp = (r_hdr0 != HDR_RECEIVE);
        end else if (r_hdr0 == HDR_VALID) begin
            w_wp = (r_hdr1 == HDR_RECEIVE);
        end else begin
            w_wp_none = 1'b1;
        end
    end

    // status toward the controller
    always_comb begin
        o_sts.key_match = (w_rdata == w_op_key);
        o_sts.hw_erased = (w_rdata == HW_ERASED);
        o_sts.flag      = r_flag;
        o_sts.slot_end  = (r_slot == SW'(PAGE_SLOTS - 1));
        o_sts.slot_one  = (r_slot == SW'(1));
        o_sts.off_last  = (r_off == OW'(PAGE_HW - 1));
        o_sts.rp_none   = w_rp_none;
        o_sts.rp        = w_rp;
        o_sts.wp_none   = w_wp_none;
        o_sts.h0        = classify(r_hdr0);
        o_sts.h1        = classify(r_hdr1);
        o_sts.idx_done  = (r_idx >= w_n);
        o_sts.idx_skip  = (w_list_key == r_skip);
    end

    // control registers: config, headers, counters, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= CNT_W'(1);
            r_key[0]    <= KEY_W'(1);
            r_key[1]    <= KEY_W'(2);
            r_key[2]    <= KEY_W'(3);
            r_key[3]    <= KEY_W'(4);
            r_hdr0      <= HDR_ERASED;
            r_hdr1      <= HDR_ERASED;
            r_page      <= 1'b0;
            r_off       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_KEY_COUNT: r_key_count <= i_cfg_data[CNT_W-1:0];
                    CFG_KEY_0:     r_key[0]    <= i_cfg_data;
                    CFG_KEY_1:     r_key[1]    <= i_cfg_data;
                    CFG_KEY_2:     r_key[2]    <= i_cfg_data;
                    CFG_KEY_3:     r_key[3]    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.mem_we && w_addr == '0) r_hdr0 <= w_wdata;
            if (i_cmd.mem_we && w_addr == AW'(PAGE_HW)) r_hdr1 <= w_wdata;
            if (i_cmd.page_ld) begin
                unique case (i_cmd.page_src)
                    PG_READ:  r_page <= w_rp;
                    PG_WRITE: r_page <= w_wp;
                    PG_CMD:   r_page <= i_cmd.page;
                    default:  r_page <= i_cmd.page;
                endcase
            end
            if (i_cmd.off_clr) r_off <= '0;
            else if (i_cmd.off_inc) r_off <= r_off + OW'(1);
            if (i_cmd.slot_top) r_slot <= SW'(PAGE_SLOTS - 1);
            else if (i_cmd.slot_zero) r_slot <= '0;
            else if (i_cmd.slot_dec) r_slot <= r_slot - SW'(1);
            else if (i_cmd.slot_inc) r_slot <= r_slot + SW'(1);
            r_out_valid <= i_cmd.res_ld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_in_key <= i_var_key;
            r_in_val <= i_write_value;
        end
        if (i_cmd.use_in) r_use_list <= 1'b0;
        else if (i_cmd.use_list) r_use_list <= 1'b1;
        if (i_cmd.flag_ld) r_flag <= (w_rdata == HW_ERASED);
        if (i_cmd.val_ld) r_val <= w_rdata;
        if (i_cmd.skip_in) r_skip <= r_in_key;
        else if (i_cmd.skip_mem) r_skip <= w_rdata;
        if (i_cmd.idx_clr) r_idx <= '0;
        else if (i_cmd.idx_inc) r_idx <= r_idx + IDX_W'(1);
        if (i_cmd.res_ld) begin
            r_status <= i_cmd.res_st;
            r_rv     <= i_cmd.res_val ? r_val : '0;
        end
    end

    assign o_status       = r_status;
    assign o_read_value   = r_rv;
    assign o_result_valid = r_out_valid;

`ifndef SYNTHESIS
    // one transaction result lasts a single cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe held two cycles");

    // slot counter stays inside the page
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SW'(PAGE_SLOTS - 1))
        else $error("slot counter out of page");

    // erase offset wraps at the page end
    a_off_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.off_inc && r_off == OW'(PAGE_HW - 1)) |=> (r_off == '0))
        else $error("erase offset ran past page");
`endif

endmodule

`default_nettype wire

// File: hdl/flash_eeprom_emulation.sv
// top level of the two page flash eeprom emulation block
// Usage: a command transaction is taken at a rising edge with start high and busy low,
// carrying i_opcode (read, write, recover, or a no-op code), i_var_key and i_write_value.
// Exactly one result follows: o_status and o_read_value are shown for one cycle with
// o_result_valid high; the receiver cannot stall and must take it in that cycle.
// Configuration transactions (key count, four listed keys) use i_cfg_valid/o_cfg_ready,
// ready is always high; write them only while the block is idle.
// Each transaction uses the single flash array port, one halfword per cycle:
//   read    a key match scan over slots from the page end, then a data read
//   write   an erased slot scan from the page start, then a data and a key write
//   page transfer  on a full page: a receive header write, the append again, a read
//           and an append for each other listed key, a page erase and a valid header write
//   recover  header writes and page erases, with a key copy like the page transfer
//           when a page beside a valid one is receiving or, for page 1, corrupt
// Items are processed one at a time; busy stays high until the result is issued.
// After reset the block clears the whole flash to erased, page 0 then page 1, with
// busy high; configuration resets to key count 1 and keys 1, 2, 3, 4.
`default_nettype none

module flash_eeprom_emulation #(
    parameter int PAGE_SLOTS = fee_pkg::DEF_PAGE_SLOTS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     i_opcode,
    input  wire logic [fee_pkg::KEY_W-1:0]      i_var_key,
    input  wire logic [fee_pkg::VAL_W-1:0]      i_write_value,
    output logic                                o_result_valid,
    output logic      [1:0]                     o_status,
    output logic      [fee_pkg::VAL_W-1:0]      o_read_value,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [fee_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fee_pkg::VAL_W-1:0]      i_cfg_data
);
    import fee_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // configuration is always accepted
    assign o_cfg_ready = 1'b1;

    fee_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (t_opcode'(i_opcode)),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    fee_dpath #(
        .PAGE_SLOTS (PAGE_SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_var_key      (i_var_key),
        .i_write_value  (i_write_value),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_status       (o_status),
        .o_read_value   (o_read_value),
        .o_result_valid (o_result_valid)
    );

endmodule

`default_nettype wire
